[hw/rtl/tvsd_pkg.sv]
// Shared types and constants for the tagged value stream decoder.
package tvsd_pkg;

  // Result kinds carried on the output tuser
  localparam logic [2:0] KIND_INT     = 3'd0;
  localparam logic [2:0] KIND_DOUBLE  = 3'd1;
  localparam logic [2:0] KIND_RAWHDR  = 3'd2;
  localparam logic [2:0] KIND_RAWBYTE = 3'd3;
  localparam logic [2:0] KIND_HOOK    = 3'd4;
  localparam logic [2:0] KIND_CODE    = 3'd5;
  localparam logic [2:0] KIND_TRUNC   = 3'd6;
  localparam logic [2:0] KIND_END     = 3'd7;

  // Header code boundaries
  localparam logic [7:0] CODE_SMALL_MAX  = 8'd63;
  localparam logic [7:0] CODE_NEG_MAX    = 8'd123;
  localparam logic [7:0] CODE_HOOK       = 8'd124;
  localparam logic [7:0] CODE_DBL_NEG1   = 8'd125;
  localparam logic [7:0] CODE_DBL_ZERO   = 8'd126;
  localparam logic [7:0] CODE_DBL_MAX    = 8'd127;
  localparam logic [7:0] CODE_RAW_BASE   = 8'd128;
  localparam logic [7:0] CODE_RAW_MAX    = 8'd227;
  localparam logic [7:0] CODE_RAWLEN_MAX = 8'd231;
  localparam logic [7:0] CODE_INT_MAX    = 8'd235;
  localparam logic [7:0] CODE_DOUBLE     = 8'd236;

  // IEEE double bit patterns for the constant doubles
  localparam logic [63:0] DBL_NEG_ONE = 64'hBFF0_0000_0000_0000;
  localparam logic [63:0] DBL_ONE     = 64'h3FF0_0000_0000_0000;

  // Results caused by one input byte: an optional token, then an optional end/truncated
  typedef struct packed {
    logic        res_v;
    logic [2:0]  res_kind;
    logic [63:0] res_value;
    logic        tail_v;
    logic [2:0]  tail_kind;
  } tvsd_pair_t;

endpackage

[hw/rtl/tvsd_parser.sv]
// Parse state and single-pass decode of one stream byte into a result pair.
module tvsd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  input  logic                final_i,
  output tvsd_pkg::tvsd_pair_t pair_o
);
  import tvsd_pkg::*;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_INT     = 3'd2;
  localparam logic [2:0] PH_DOUBLE  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  wlog_q, wlog_d;     // log2 of the field width in bytes
  logic [3:0]  need_q, need_d;
  logic [63:0] gath_q, gath_d;
  logic [63:0] left_q, left_d;

  logic        take_hdr;
  logic [3:0]  fw;
  logic [2:0]  pos;
  logic [3:0]  need_dec;
  logic [63:0] gath_ins;
  logic [63:0] int_ext;
  logic [7:0]  neg_small;

  assign fw        = 4'd1 << wlog_q;
  assign pos       = 3'(fw - need_q);
  assign need_dec  = need_q - 4'd1;
  assign neg_small = CODE_SMALL_MAX - byte_i;

  // Insert the byte into its little-endian lane
  always_comb begin
    gath_ins = gath_q;
    for (int i = 0; i < 8; i++) begin
      if (pos == 3'(i)) gath_ins[i*8 +: 8] = gath_q[i*8 +: 8] | byte_i;
    end
  end

  // Sign extension of a finished integer field
  always_comb begin
    case (wlog_q)
      2'd0:    int_ext = {{56{gath_ins[7]}}, gath_ins[7:0]};
      2'd1:    int_ext = {{48{gath_ins[15]}}, gath_ins[15:0]};
      2'd2:    int_ext = {{32{gath_ins[31]}}, gath_ins[31:0]};
      default: int_ext = gath_ins;
    endcase
  end

  // Next state and results
  always_comb begin
    phase_d  = phase_q;
    wlog_d   = wlog_q;
    need_d   = need_q;
    gath_d   = gath_q;
    left_d   = left_q;
    pair_o   = '0;
    take_hdr = 1'b0;

    unique case (phase_q)
      PH_LENGTH, PH_INT, PH_DOUBLE: begin
        if (need_q == 4'd0 || need_q > 4'd8) begin
          take_hdr = 1'b1;
        end else begin
          need_d = need_dec;
          gath_d = gath_ins;
          if (need_dec == 4'd0) begin
            gath_d       = '0;
            phase_d      = PH_HEADER;
            pair_o.res_v = 1'b1;
            if (phase_q == PH_LENGTH) begin
              pair_o.res_kind  = KIND_RAWHDR;
              pair_o.res_value = gath_ins;
              if (gath_ins != 64'd0) begin
                left_d  = gath_ins;
                phase_d = PH_PAYLOAD;
              end
            end else if (phase_q == PH_INT) begin
              pair_o.res_kind  = KIND_INT;
              pair_o.res_value = int_ext;
            end else begin
              pair_o.res_kind  = KIND_DOUBLE;
              pair_o.res_value = gath_ins;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        pair_o.res_v     = 1'b1;
        pair_o.res_kind  = KIND_RAWBYTE;
        pair_o.res_value = {56'd0, byte_i};
        left_d           = left_q - 64'd1;
        if (left_d == 64'd0) phase_d = PH_HEADER;
      end
      default: take_hdr = 1'b1;
    endcase

    // Header byte decode
    if (take_hdr) begin
      phase_d = PH_HEADER;
      if (byte_i <= CODE_SMALL_MAX) begin
        pair_o.res_v     = 1'b1;
        pair_o.res_kind  = KIND_INT;
        pair_o.res_value = {56'd0, byte_i};
      end else if (byte_i <= CODE_NEG_MAX) begin
        pair_o.res_v     = 1'b1;
        pair_o.res_kind  = KIND_INT;
        pair_o.res_value = {{56{neg_small[7]}}, neg_small};
      end else if (byte_i == CODE_HOOK) begin
        pair_o.res_v     = 1'b1;
        pair_o.res_kind  = KIND_HOOK;
      end else if (byte_i <= CODE_DBL_MAX) begin
        pair_o.res_v     = 1'b1;
        pair_o.res_kind  = KIND_DOUBLE;
        pair_o.res_value = (byte_i == CODE_DBL_NEG1) ? DBL_NEG_ONE :
                           (byte_i == CODE_DBL_ZERO) ? 64'd0 : DBL_ONE;
      end else if (byte_i <= CODE_RAW_MAX) begin
        pair_o.res_v     = 1'b1;
        pair_o.res_kind  = KIND_RAWHDR;
        pair_o.res_value = {56'd0, byte_i - CODE_RAW_BASE};
        if (byte_i != CODE_RAW_BASE) begin
          left_d  = {56'd0, byte_i - CODE_RAW_BASE};
          phase_d = PH_PAYLOAD;
        end
      end else if (byte_i <= CODE_DOUBLE) begin
        gath_d = '0;
        if (byte_i == CODE_DOUBLE) begin
          wlog_d  = 2'd3;
          need_d  = 4'd8;
          phase_d = PH_DOUBLE;
        end else begin
          wlog_d  = byte_i[1:0];
          need_d  = 4'd1 << byte_i[1:0];
          phase_d = (byte_i <= CODE_RAWLEN_MAX) ? PH_LENGTH : PH_INT;
        end
      end else begin
        pair_o.res_v     = 1'b1;
        pair_o.res_kind  = KIND_CODE;
        pair_o.res_value = {56'd0, byte_i};
      end
    end

    // Last byte of the buffer: close it and return to reset state
    if (final_i) begin
      pair_o.tail_v    = 1'b1;
      pair_o.tail_kind = (phase_d == PH_HEADER) ? KIND_END : KIND_TRUNC;
      phase_d = PH_HEADER;
      wlog_d  = 2'd3;
      need_d  = '0;
      gath_d  = '0;
      left_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      wlog_q  <= 2'd3;
      need_q  <= '0;
      gath_q  <= '0;
      left_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      wlog_q  <= wlog_d;
      need_q  <= need_d;
      gath_q  <= gath_d;
      left_q  <= left_d;
    end
  end

  // Payload phase always has bytes left to forward
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> left_q != 64'd0)
    else $error("payload phase with zero bytes left");

  // Field phases keep a byte count within the field width
  a_need_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LENGTH || phase_q == PH_INT || phase_q == PH_DOUBLE)
      |-> (need_q != 4'd0 && need_q <= fw))
    else $error("field byte count out of range");

endmodule

[hw/rtl/tvsd_out.sv]
// Result register with a skid stage; serializes each result pair onto the output.
module tvsd_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tvsd_pkg::tvsd_pair_t pair_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [2:0]           kind_o,
  output logic [63:0]          value_o,
  output logic                 last_o
);
  import tvsd_pkg::*;

  tvsd_pair_t cur_q, cur_d;
  tvsd_pair_t skid_q, skid_d;
  logic       skid_v_q, skid_v_d;
  logic       fire;
  logic       cur_done;
  logic       cur_free;

  assign valid_o  = cur_q.res_v | cur_q.tail_v;
  assign fire     = valid_o & ready_i;
  assign cur_done = fire & ~(cur_q.res_v & cur_q.tail_v);
  assign cur_free = ~valid_o | cur_done;
  assign ready_o  = ~skid_v_q;

  // Token first, then the end/truncated marker
  assign kind_o  = cur_q.res_v ? cur_q.res_kind : cur_q.tail_kind;
  assign value_o = cur_q.res_v ? cur_q.res_value : 64'd0;
  assign last_o  = cur_q.res_v ? ~cur_q.tail_v : 1'b1;

  always_comb begin
    cur_d    = cur_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (fire) cur_d.res_v = 1'b0;
    if (cur_done) cur_d.tail_v = 1'b0;
    if (push_i) begin
      if (cur_free) begin
        cur_d = pair_i;
      end else begin
        skid_d   = pair_i;
        skid_v_d = 1'b1;
      end
    end else if (cur_free && skid_v_q) begin
      cur_d    = skid_q;
      skid_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      skid_v_q <= 1'b0;
    end else begin
      cur_q    <= cur_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    skid_q <= skid_d;
  end

  // The skid stage only fills behind a busy result register
  a_skid_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> valid_o)
    else $error("skid stage holds a pair with the result register empty");

  // A push into a busy, unfinished result register lands in the skid stage
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && valid_o && !cur_done) |=> skid_v_q)
    else $error("pushed pair lost while result register busy");

endmodule

[hw/rtl/tagged_value_stream_decoder.sv]
// Top level of the tagged value stream decoder.
//
//  Channel  Dir  Signals                   Contents
//  s_axis   in   tvalid/tready/tdata/tlast tdata[7:0] data_byte; tlast final_byte
//  m_axis   out  tvalid/tready/tdata/tuser tdata[63:0] value; tuser[2:0] kind;
//                /tlast                    tlast run_last
//
// One byte is taken per cycle while the skid stage is empty; the parse state and the
// decode of that byte settle in the same cycle and land in the result register. A byte
// causing two results (a token followed by end or truncated) sends both, token first. A
// skid stage behind the result register lets one more byte in while a result waits, so
// the input stalls only when both are full. Reset is asynchronous and active low and
// leaves the block expecting a header byte with no results pending.
module tagged_value_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] value
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);
  import tvsd_pkg::*;

  tvsd_pair_t pair;
  logic       in_fire;
  logic       push;

  assign in_fire = s_axis_tvalid & s_axis_tready;
  assign push    = in_fire & (pair.res_v | pair.tail_v);

  // Byte decode and parse state
  tvsd_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (in_fire),
    .byte_i  (s_axis_tdata),
    .final_i (s_axis_tlast),
    .pair_o  (pair)
  );

  // Result register, skid stage and output sequencing
  tvsd_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pair_i  (pair),
    .ready_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .kind_o  (m_axis_tuser),
    .value_o (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the tagged value stream decoder.
`timescale 1ns / 100ps

module tb_top;
  import tvsd_pkg::*;

  localparam int NDIR        = 25;
  localparam int RAND_ITEMS  = 1450;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;

  // Parse phases of the byte decoder
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_INT     = 3'd2,
    PH_DOUBLE  = 3'd3,
    PH_PAYLOAD = 3'd4
  } parse_phase_e;

  // One decoded token as seen on the output stream
  typedef struct {
    logic [2:0]  kind;
    logic [63:0] value;
    logic        last;
  } decoded_tok_t;

  // One input byte; typed rows carry their results, others use the decoder model
  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic        typed;
    logic [1:0]  n_res;
    logic [2:0]  k0;
    logic [63:0] v0;
    logic [2:0]  k1;
    logic [63:0] v1;
  } stim_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  tagged_value_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Model state of the decoder
  parse_phase_e ph          = PH_HEADER;
  logic [7:0]   hdr_code    = 8'd0;
  logic [3:0]   need_cnt    = 4'd0;
  logic [63:0]  gather_acc  = 64'd0;
  logic [63:0]  payload_cnt = 64'd0;

  decoded_tok_t step_out[$];
  decoded_tok_t pending_tokens[$];
  stim_row_t    frame_q[$];

  int items_sent      = 0;
  int results_seen    = 0;
  int errors          = 0;
  int in_stall_cycles = 0;
  int kind_seen [8];
  bit tx_burst        = 1'b0;
  bit rx_burst        = 1'b0;
  logic hold_rx       = 1'b0;

  // Directed bytes: value extremes, every header class, raw timing, truncation
  stim_row_t dir_rows [NDIR] = '{
    '{8'd0,   1'b0, 1'b1, 2'd1, KIND_INT,     64'd0,     KIND_INT, 64'd0},
    '{8'd63,  1'b0, 1'b1, 2'd1, KIND_INT,     64'd63,    KIND_INT, 64'd0},
    '{8'd64,  1'b0, 1'b1, 2'd1, KIND_INT,     '1,        KIND_INT, 64'd0},
    '{8'd123, 1'b0, 1'b1, 2'd1, KIND_INT,     64'hFFFF_FFFF_FFFF_FFC4, KIND_INT, 64'd0},
    '{8'd124, 1'b0, 1'b1, 2'd1, KIND_HOOK,    64'd0,     KIND_INT, 64'd0},
    '{8'd125, 1'b0, 1'b1, 2'd1, KIND_DOUBLE,  DBL_NEG_ONE, KIND_INT, 64'd0},
    '{8'd126, 1'b0, 1'b1, 2'd1, KIND_DOUBLE,  64'd0,     KIND_INT, 64'd0},
    '{8'd127, 1'b0, 1'b1, 2'd1, KIND_DOUBLE,  DBL_ONE,   KIND_INT, 64'd0},
    '{8'd237, 1'b0, 1'b1, 2'd1, KIND_CODE,    64'd237,   KIND_INT, 64'd0},
    '{8'd255, 1'b1, 1'b1, 2'd2, KIND_CODE,    64'd255,   KIND_END, 64'd0},
    // zero-length raw string gives only its header
    '{8'd128, 1'b0, 1'b1, 2'd1, KIND_RAWHDR,  64'd0,     KIND_INT, 64'd0},
    '{8'd130, 1'b0, 1'b1, 2'd1, KIND_RAWHDR,  64'd2,     KIND_INT, 64'd0},
    '{8'hAA,  1'b0, 1'b0, 2'd0, KIND_INT,     64'd0,     KIND_INT, 64'd0},
    '{8'h55,  1'b0, 1'b0, 2'd0, KIND_INT,     64'd0,     KIND_INT, 64'd0},
    // length counted after the length byte
    '{8'd228, 1'b0, 1'b1, 2'd0, KIND_INT,     64'd0,     KIND_INT, 64'd0},
    '{8'd1,   1'b0, 1'b1, 2'd1, KIND_RAWHDR,  64'd1,     KIND_INT, 64'd0},
    '{8'hFF,  1'b0, 1'b1, 2'd1, KIND_RAWBYTE, 64'hFF,    KIND_INT, 64'd0},
    // 16-bit integer, sign extended
    '{8'd233, 1'b0, 1'b1, 2'd0, KIND_INT,     64'd0,     KIND_INT, 64'd0},
    '{8'h00,  1'b0, 1'b1, 2'd0, KIND_INT,     64'd0,     KIND_INT, 64'd0},
    '{8'h80,  1'b0, 1'b1, 2'd1, KIND_INT,     64'hFFFF_FFFF_FFFF_8000, KIND_INT, 64'd0},
    // buffer ends inside a double
    '{8'd236, 1'b0, 1'b1, 2'd0, KIND_INT,     64'd0,     KIND_INT, 64'd0},
    '{8'h12,  1'b1, 1'b1, 2'd1, KIND_TRUNC,   64'd0,     KIND_INT, 64'd0},
    // buffer ends right after a raw header
    '{8'd227, 1'b1, 1'b1, 2'd2, KIND_RAWHDR,  64'd99,    KIND_TRUNC, 64'd0},
    '{8'd232, 1'b0, 1'b0, 2'd0, KIND_INT,     64'd0,     KIND_INT, 64'd0},
    '{8'h7F,  1'b1, 1'b0, 2'd0, KIND_INT,     64'd0,     KIND_INT, 64'd0}
  };

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  function automatic void add_tok(logic [2:0] k, logic [63:0] v);
    decoded_tok_t t;
    t.kind  = k;
    t.value = v;
    t.last  = 1'b0;
    step_out.push_back(t);
  endfunction

  function automatic void reset_parser();
    ph          = PH_HEADER;
    hdr_code    = 8'd0;
    need_cnt    = 4'd0;
    gather_acc  = 64'd0;
    payload_cnt = 64'd0;
  endfunction

  // Bytes in the field behind a multi-byte header
  function automatic int unsigned field_bytes(logic [7:0] c);
    if (c > CODE_RAW_MAX && c <= CODE_INT_MAX) begin
      return 1 << c[1:0];
    end
    return 8;
  endfunction

  function automatic void take_header(logic [7:0] c);
    logic [63:0] len;
    if (c <= CODE_SMALL_MAX) begin
      add_tok(KIND_INT, 64'(c));
    end else if (c <= CODE_NEG_MAX) begin
      add_tok(KIND_INT, 64'(CODE_SMALL_MAX) - 64'(c));
    end else if (c == CODE_HOOK) begin
      add_tok(KIND_HOOK, 64'd0);
    end else if (c <= CODE_DBL_MAX) begin
      add_tok(KIND_DOUBLE, (c == CODE_DBL_NEG1) ? DBL_NEG_ONE :
                           (c == CODE_DBL_ZERO) ? 64'd0 : DBL_ONE);
    end else if (c <= CODE_RAW_MAX) begin
      len = 64'(c - CODE_RAW_BASE);
      add_tok(KIND_RAWHDR, len);
      if (len != 0) begin
        payload_cnt = len;
        ph          = PH_PAYLOAD;
      end
    end else if (c <= CODE_DOUBLE) begin
      hdr_code   = c;
      need_cnt   = 4'(field_bytes(c));
      gather_acc = 64'd0;
      ph = (c <= CODE_RAWLEN_MAX) ? PH_LENGTH : (c <= CODE_INT_MAX) ? PH_INT : PH_DOUBLE;
    end else begin
      add_tok(KIND_CODE, 64'(c));
    end
  endfunction

  // Collect one little-endian field byte; emit once the field is whole
  function automatic void take_gather(logic [7:0] b);
    int unsigned w;
    int unsigned pos;
    logic [63:0] v;
    logic [63:0] sign;
    w = field_bytes(hdr_code);
    pos = (w - need_cnt) & 7;
    gather_acc = gather_acc | (64'(b) << (pos * 8));
    need_cnt = need_cnt - 4'd1;
    if (need_cnt != 0) return;
    case (ph)
      PH_LENGTH: begin
        add_tok(KIND_RAWHDR, gather_acc);
        if (gather_acc != 0) begin
          payload_cnt = gather_acc;
          ph          = PH_PAYLOAD;
        end else begin
          ph = PH_HEADER;
        end
      end
      PH_INT: begin
        v = gather_acc;
        if (w < 8) begin
          sign = 64'd1 << (w * 8 - 1);
          v = (v ^ sign) - sign;
        end
        add_tok(KIND_INT, v);
        ph = PH_HEADER;
      end
      default: begin
        add_tok(KIND_DOUBLE, gather_acc);
        ph = PH_HEADER;
      end
    endcase
    gather_acc = 64'd0;
  endfunction

  // Results one input byte causes, left in step_out
  function automatic void decode_byte(logic [7:0] b, logic fin);
    step_out.delete();
    case (ph)
      PH_LENGTH, PH_INT, PH_DOUBLE: begin
        if (need_cnt == 0 || need_cnt > 8) begin
          ph = PH_HEADER;
          take_header(b);
        end else begin
          take_gather(b);
        end
      end
      PH_PAYLOAD: begin
        add_tok(KIND_RAWBYTE, 64'(b));
        payload_cnt = payload_cnt - 64'd1;
        if (payload_cnt == 0) ph = PH_HEADER;
      end
      default: begin
        ph = PH_HEADER;
        take_header(b);
      end
    endcase
    if (fin) begin
      add_tok((ph == PH_HEADER) ? KIND_END : KIND_TRUNC, 64'd0);
      reset_parser();
    end
    if (step_out.size() > 0) step_out[$].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones, none in burst mode
  function automatic int idle_len(bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put(logic [7:0] b);
    stim_row_t r;
    r = '0;
    r.data = b;
    frame_q.push_back(r);
  endfunction

  function automatic void put_le(logic [63:0] v, int unsigned w);
    for (int i = 0; i < w; i++) put(v[8*i +: 8]);
  endfunction

  function automatic void put_payload(int unsigned len);
    for (int i = 0; i < len; i++) put(8'($urandom_range(0, 255)));
  endfunction

  // Append one well-formed token with random content
  function automatic void put_token();
    int unsigned sel;
    int unsigned len;
    int unsigned w;
    logic [7:0]  code;
    sel = $urandom_range(0, 9);
    case (sel)
      0: put(8'($urandom_range(0, CODE_SMALL_MAX)));
      1: put(8'($urandom_range(CODE_SMALL_MAX + 1, CODE_NEG_MAX)));
      2: put(8'($urandom_range(CODE_HOOK, CODE_DBL_MAX)));
      3: put(8'($urandom_range(CODE_DOUBLE + 1, 8'hFF)));
      4, 5: begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 6);
        put(CODE_RAW_BASE + 8'(len));
        put_payload(len);
      end
      6: begin
        code = 8'($urandom_range(CODE_RAW_MAX + 1, CODE_RAWLEN_MAX));
        w    = 1 << code[1:0];
        len  = $urandom_range(0, 8);
        if (w > 1 && $urandom_range(0, 7) == 0) len = $urandom_range(0, 300);
        put(code);
        put_le(64'(len), w);
        put_payload(len);
      end
      7, 8: begin
        code = 8'($urandom_range(CODE_RAWLEN_MAX + 1, CODE_INT_MAX));
        put(code);
        put_le({$urandom, $urandom}, 1 << code[1:0]);
      end
      default: begin
        put(CODE_DOUBLE);
        put_le({$urandom, $urandom}, 8);
      end
    endcase
  endfunction

  // One buffer: mostly complete, some cut short, some raw noise
  function automatic void gen_frame();
    int unsigned sel;
    int unsigned n;
    sel = $urandom_range(0, 99);
    frame_q.delete();
    if (sel < 8) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        put(8'($urandom_range(0, 255)));
        frame_q[$].fin = ($urandom_range(0, 5) == 0);
      end
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) put_token();
      if (sel < 20) begin
        n = $urandom_range(1, frame_q.size());
        while (frame_q.size() > n) void'(frame_q.pop_back());
      end
      frame_q[$].fin = 1'b1;
    end
  endfunction

  // Offer one byte, wait for its transfer, queue its expected results
  task automatic offer(input stim_row_t r);
    int gap;
    gap = idle_len(tx_burst);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r.data;
    s_axis_tlast  <= r.fin;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(r.data, r.fin);
    if (r.typed) begin
      step_out.delete();
      if (r.n_res >= 1) step_out.push_back('{r.k0, r.v0, r.n_res == 1});
      if (r.n_res == 2) step_out.push_back('{r.k1, r.v1, 1'b1});
    end
    foreach (step_out[i]) pending_tokens.push_back(step_out[i]);
    items_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Output checking
  // ---------------------------------------------------------------------------

  function automatic void check_result();
    decoded_tok_t exp_tok;
    results_seen++;
    kind_seen[m_axis_tuser]++;
    if (pending_tokens.size() == 0) begin
      $error("unexpected result: kind %0d value %h run_last %0b",
             m_axis_tuser, m_axis_tdata, m_axis_tlast);
      errors++;
      return;
    end
    exp_tok = pending_tokens.pop_front();
    if (m_axis_tuser !== exp_tok.kind) begin
      $error("kind: expected %0d, got %0d", exp_tok.kind, m_axis_tuser);
      errors++;
    end
    if (m_axis_tdata !== exp_tok.value) begin
      $error("value: expected %h, got %h", exp_tok.value, m_axis_tdata);
      errors++;
    end
    if (m_axis_tlast !== exp_tok.last) begin
      $error("run_last: expected %0b, got %0b", exp_tok.last, m_axis_tlast);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Processes
  // ---------------------------------------------------------------------------

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: random stalls, burst stretches, and the long hold-off
  initial begin
    int rx_stall;
    rx_stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && !s_axis_tready) in_stall_cycles++;
      if ($urandom_range(0, 199) == 0) rx_burst = !rx_burst;
      if (rx_stall > 0) begin
        rx_stall--;
      end else if ($urandom_range(0, 3) == 0) begin
        rx_stall = idle_len(rx_burst);
      end
      m_axis_tready <= !hold_rx && (rx_stall == 0);
    end
  end

  // Long receiver hold-off so the decoder fills up and stalls its input
  initial begin
    wait (items_sent >= NDIR + 600);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $error("timeout after %0d cycles, %0d results outstanding",
           cycles, pending_tokens.size());
    $display("status: fail");
    $finish;
  end

  // Main sequence
  initial begin
    foreach (kind_seen[i]) kind_seen[i] = 0;
    reset_parser();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < NDIR; i++) offer(dir_rows[i]);

    // random buffers
    while (items_sent < NDIR + RAND_ITEMS) begin
      gen_frame();
      tx_burst = ($urandom_range(0, 3) == 0);
      foreach (frame_q[i]) offer(frame_q[i]);
    end
    s_axis_tvalid <= 1'b0;

    // drain, then keep the clock running idle to catch stray results
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("run covered %0d input bytes and %0d results, %0d stalled input cycles",
             items_sent, results_seen, in_stall_cycles);
    $display("kinds int/dbl/rawhdr/rawbyte/hook/code/trunc/end: %0d %0d %0d %0d %0d %0d %0d %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
